/* src/conv3x3_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3x3_pkg
// Shared constants, register indexes and payload types of the 3x3
// correlation filter.
// ----------------------------------------------------------------------------
package conv3x3_pkg;

    // Geometry and arithmetic sizes.
    localparam int unsigned MAX_WIDTH   = 1024;
    localparam int unsigned MAX_HEIGHT  = 1024;
    localparam int unsigned MIN_SIZE    = 3;
    localparam int unsigned KERNEL_SIZE = 3;
    localparam int unsigned CHANNELS    = 3;
    localparam int unsigned SAMPLE_BITS = 8;
    localparam int unsigned COEF_BITS   = 16;
    localparam int unsigned ROW_BITS    = 48;
    localparam int unsigned SIZE_BITS   = 11;
    localparam int unsigned PIX_BITS    = CHANNELS * SAMPLE_BITS;
    localparam int unsigned PROD_BITS   = SAMPLE_BITS + COEF_BITS;
    localparam int unsigned RSUM_BITS   = PROD_BITS + 2;
    localparam int unsigned SUM_BITS    = PROD_BITS + 4;
    localparam int unsigned CFG_IDX_BITS = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_TOP    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_MID    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT  = 3'd4;

    // Input pixel transfer.
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] pixel_ch0;
        logic [SAMPLE_BITS-1:0] pixel_ch1;
        logic [SAMPLE_BITS-1:0] pixel_ch2;
        logic                   start_of_frame;
    } t_pixel_in;

    // Output result transfer.
    typedef struct packed {
        logic [SUM_BITS-1:0] sum_ch0;
        logic [SUM_BITS-1:0] sum_ch1;
        logic [SUM_BITS-1:0] sum_ch2;
        logic                last_in_frame;
    } t_sum_out;

    // One window column: index 0 is the oldest row, channel 0 in the low byte.
    typedef logic [KERNEL_SIZE-1:0][CHANNELS-1:0][SAMPLE_BITS-1:0] t_column;

    // Full 3x3 window handed to the multiply-accumulate pipeline.
    typedef struct packed {
        t_column [KERNEL_SIZE-1:0] cols;
        logic                      last;
    } t_window;

    // Kernel rows, column 0 in the low coefficient of each row.
    typedef logic [KERNEL_SIZE-1:0][ROW_BITS-1:0] t_kernel;

endpackage

/* src/conv3x3_image_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3x3_image_filter
// 3x3 correlation of a three-channel raster stream with a configurable
// unsigned Q0.16 kernel, giving exact Q12.16 sums for interior positions.
// ----------------------------------------------------------------------------
// The filter takes one pixel transfer per clock cycle while the output is
// not stalled and gives one result for every pixel whose 3x3 window lies
// inside the image; pixels in the first two rows and columns give none.
// Throughput is set by the line memory, which holds the two previous rows,
// is read at the column of each incoming pixel and written back as that
// pixel leaves the second stage, one read and one write per cycle; a
// back-to-back access to the same column is forwarded. The memory needs no
// clearing after reset. Back-pressure on the output stalls the pipeline
// only as far as its empty stages allow. Kernel and image size must be
// written while no pixel is in flight.
// ----------------------------------------------------------------------------
module conv3x3_image_filter #(
    parameter int unsigned MAX_WIDTH = conv3x3_pkg::MAX_WIDTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  conv3x3_pkg::t_pixel_in                 i_in_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output conv3x3_pkg::t_sum_out                  o_out_data,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [conv3x3_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [conv3x3_pkg::ROW_BITS-1:0]       i_cfg_data
);

    localparam int unsigned KS    = conv3x3_pkg::KERNEL_SIZE;
    localparam int unsigned PXB   = conv3x3_pkg::PIX_BITS;
    localparam int unsigned SZB   = conv3x3_pkg::SIZE_BITS;
    localparam int unsigned COL_W = $clog2(MAX_WIDTH);
    localparam int unsigned WID_W = $clog2(MAX_WIDTH + 1);
    localparam int unsigned CMP_W = (WID_W > SZB) ? WID_W : SZB;
    localparam int unsigned ROW_W = $clog2(conv3x3_pkg::MAX_HEIGHT);
    localparam int unsigned HGT_W = SZB;

    // Configuration registers.
    conv3x3_pkg::t_kernel r_kernel;
    logic [SZB-1:0]       r_width;
    logic [SZB-1:0]       r_height;

    // Position of the next pixel.
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    // Position logic.
    logic [CMP_W-1:0] wid_ext, eff_w, col_inc;
    logic [HGT_W-1:0] eff_h, row1, row_inc;
    logic [COL_W-1:0] col0, cur_c, n_col;
    logic [ROW_W-1:0] row0, cur_r, n_row;
    logic             cur_emit, cur_last;
    logic             in_go;

    // Line memory: upper row in the high half, lower row in the low half.
    logic [2*PXB-1:0] mem [MAX_WIDTH];
    logic [2*PXB-1:0] r_rd_data;

    // Second stage: memory data available, window update.
    logic             r_s1_valid;
    logic [COL_W-1:0] r_s1_addr;
    logic [PXB-1:0]   r_s1_pix;
    logic             r_s1_emit;
    logic             r_s1_last;
    logic             r_s1_fwd;
    logic [2*PXB-1:0] r_s1_fwd_data;
    logic [PXB-1:0]   col_upper, col_lower;
    logic [2*PXB-1:0] wr_data;
    logic             s1_go;

    conv3x3_pkg::t_column r_win0, r_win1, cur_col;
    conv3x3_pkg::t_window mac_win;
    logic                 mac_ready;

    // Configuration writes; indexes past the list are ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel <= '0;
            r_width  <= SZB'(conv3x3_pkg::MAX_WIDTH);
            r_height <= SZB'(conv3x3_pkg::MAX_HEIGHT);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                conv3x3_pkg::REG_KERNEL_TOP:    r_kernel[0] <= i_cfg_data;
                conv3x3_pkg::REG_KERNEL_MID:    r_kernel[1] <= i_cfg_data;
                conv3x3_pkg::REG_KERNEL_BOTTOM: r_kernel[2] <= i_cfg_data;
                conv3x3_pkg::REG_IMAGE_WIDTH:   r_width     <= i_cfg_data[SZB-1:0];
                conv3x3_pkg::REG_IMAGE_HEIGHT:  r_height    <= i_cfg_data[SZB-1:0];
                default: ;
            endcase
        end
    end

    // Effective image size, clamped to the supported range.
    always_comb begin
        wid_ext = CMP_W'(r_width);
        if (wid_ext < CMP_W'(conv3x3_pkg::MIN_SIZE)) begin
            eff_w = CMP_W'(conv3x3_pkg::MIN_SIZE);
        end else if (wid_ext > CMP_W'(MAX_WIDTH)) begin
            eff_w = CMP_W'(MAX_WIDTH);
        end else begin
            eff_w = wid_ext;
        end
        if (r_height < HGT_W'(conv3x3_pkg::MIN_SIZE)) begin
            eff_h = HGT_W'(conv3x3_pkg::MIN_SIZE);
        end else if (r_height > HGT_W'(conv3x3_pkg::MAX_HEIGHT)) begin
            eff_h = HGT_W'(conv3x3_pkg::MAX_HEIGHT);
        end else begin
            eff_h = r_height;
        end
    end

    // Position of the incoming pixel and of the one after it. A start of
    // frame restarts at the origin; a held position beyond a reduced size
    // moves on to the next row or wraps to the first.
    always_comb begin
        col0 = i_in_data.start_of_frame ? '0 : r_col;
        row0 = i_in_data.start_of_frame ? '0 : r_row;
        if (CMP_W'(col0) >= eff_w) begin
            cur_c = '0;
            row1  = HGT_W'(row0) + HGT_W'(1);
        end else begin
            cur_c = col0;
            row1  = HGT_W'(row0);
        end
        cur_r   = (row1 >= eff_h) ? '0 : row1[ROW_W-1:0];
        col_inc = CMP_W'(cur_c) + CMP_W'(1);
        row_inc = HGT_W'(cur_r) + HGT_W'(1);
        if (col_inc >= eff_w) begin
            n_col = '0;
            n_row = (row_inc >= eff_h) ? '0 : row_inc[ROW_W-1:0];
        end else begin
            n_col = col_inc[COL_W-1:0];
            n_row = cur_r;
        end
        cur_emit = (cur_c >= COL_W'(KS - 1)) && (cur_r >= ROW_W'(KS - 1));
        cur_last = (HGT_W'(cur_r) == eff_h - HGT_W'(1))
                && (CMP_W'(cur_c) == eff_w - CMP_W'(1));
    end

    // Handshake: the second stage moves on when the pixel gives no result
    // or the multiply-accumulate pipeline takes the window.
    assign s1_go      = r_s1_valid && (!r_s1_emit || mac_ready);
    assign o_in_ready = !r_s1_valid || s1_go;
    assign in_go      = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (o_in_ready) r_s1_valid <= i_in_valid;
            if (in_go) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // Capture the pixel; forward the write-back when it hits the column
    // being read in the same cycle.
    always_ff @(posedge i_clk) begin
        if (in_go) begin
            r_s1_addr     <= cur_c;
            r_s1_pix      <= {i_in_data.pixel_ch2, i_in_data.pixel_ch1,
                              i_in_data.pixel_ch0};
            r_s1_emit     <= cur_emit;
            r_s1_last     <= cur_last;
            r_s1_fwd      <= s1_go && (r_s1_addr == cur_c);
            r_s1_fwd_data <= wr_data;
        end
    end

    // Line memory: read at the new column, write back at the held column.
    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            mem[r_s1_addr] <= wr_data;
        end
        if (in_go) begin
            r_rd_data <= mem[cur_c];
        end
    end

    // Column of the current pixel: oldest row first.
    assign col_upper  = r_s1_fwd ? r_s1_fwd_data[2*PXB-1:PXB] : r_rd_data[2*PXB-1:PXB];
    assign col_lower  = r_s1_fwd ? r_s1_fwd_data[PXB-1:0]     : r_rd_data[PXB-1:0];
    assign wr_data    = {col_lower, r_s1_pix};
    assign cur_col[0] = col_upper;
    assign cur_col[1] = col_lower;
    assign cur_col[2] = r_s1_pix;

    // Window shift.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win0 <= '0;
            r_win1 <= '0;
        end else if (s1_go) begin
            r_win0 <= r_win1;
            r_win1 <= cur_col;
        end
    end

    assign mac_win.cols[0] = r_win0;
    assign mac_win.cols[1] = r_win1;
    assign mac_win.cols[2] = cur_col;
    assign mac_win.last    = r_s1_last;

    conv3x3_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_kernel (r_kernel),
        .i_valid  (r_s1_valid && r_s1_emit),
        .o_ready  (mac_ready),
        .i_window (mac_win),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_data   (o_out_data)
    );

endmodule

/* src/conv3x3_mac.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3x3_mac
// Pipelined multiply-accumulate for one 3x3 window on three channels:
// window register, product register, row-sum register and output register.
// ----------------------------------------------------------------------------
module conv3x3_mac (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  conv3x3_pkg::t_kernel  i_kernel,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  conv3x3_pkg::t_window  i_window,
    output logic                  o_valid,
    input  logic                  i_ready,
    output conv3x3_pkg::t_sum_out o_data
);

    localparam int unsigned CH  = conv3x3_pkg::CHANNELS;
    localparam int unsigned KS  = conv3x3_pkg::KERNEL_SIZE;
    localparam int unsigned CB  = conv3x3_pkg::COEF_BITS;
    localparam int unsigned PB  = conv3x3_pkg::PROD_BITS;
    localparam int unsigned RB  = conv3x3_pkg::RSUM_BITS;
    localparam int unsigned SB  = conv3x3_pkg::SUM_BITS;

    // Stage valids and the ready chain from the output backwards.
    logic r_a_valid, r_b_valid, r_c_valid, r_d_valid;
    logic rdy_a, rdy_b, rdy_c, rdy_d;

    conv3x3_pkg::t_window r_a;
    logic [CH-1:0][KS-1:0][KS-1:0][PB-1:0] r_prod, n_prod;
    logic [CH-1:0][KS-1:0][RB-1:0]         r_rsum, n_rsum;
    logic [CH-1:0][SB-1:0]                 r_sum,  n_sum;
    logic r_b_last, r_c_last, r_d_last;

    assign rdy_d   = !r_d_valid || i_ready;
    assign rdy_c   = !r_c_valid || rdy_d;
    assign rdy_b   = !r_b_valid || rdy_c;
    assign rdy_a   = !r_a_valid || rdy_b;
    assign o_ready = rdy_a;

    // Products of every sample with its coefficient.
    always_comb begin
        for (int ch = 0; ch < CH; ch++) begin
            for (int kr = 0; kr < KS; kr++) begin
                for (int kc = 0; kc < KS; kc++) begin
                    n_prod[ch][kr][kc] = PB'(r_a.cols[kc][kr][ch])
                                       * PB'(i_kernel[kr][kc*CB +: CB]);
                end
            end
        end
    end

    // Sums along each kernel row.
    always_comb begin
        for (int ch = 0; ch < CH; ch++) begin
            for (int kr = 0; kr < KS; kr++) begin
                n_rsum[ch][kr] = '0;
                for (int kc = 0; kc < KS; kc++) begin
                    n_rsum[ch][kr] = n_rsum[ch][kr] + RB'(r_prod[ch][kr][kc]);
                end
            end
        end
    end

    // Final sum over the three row sums.
    always_comb begin
        for (int ch = 0; ch < CH; ch++) begin
            n_sum[ch] = '0;
            for (int kr = 0; kr < KS; kr++) begin
                n_sum[ch] = n_sum[ch] + SB'(r_rsum[ch][kr]);
            end
        end
    end

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (rdy_a) r_a_valid <= i_valid;
            if (rdy_b) r_b_valid <= r_a_valid;
            if (rdy_c) r_c_valid <= r_b_valid;
            if (rdy_d) r_d_valid <= r_c_valid;
        end
    end

    // Stage payloads move only with their valid flag.
    always_ff @(posedge i_clk) begin
        if (rdy_a && i_valid) begin
            r_a <= i_window;
        end
        if (rdy_b && r_a_valid) begin
            r_prod   <= n_prod;
            r_b_last <= r_a.last;
        end
        if (rdy_c && r_b_valid) begin
            r_rsum   <= n_rsum;
            r_c_last <= r_b_last;
        end
        if (rdy_d && r_c_valid) begin
            r_sum    <= n_sum;
            r_d_last <= r_c_last;
        end
    end

    assign o_valid              = r_d_valid;
    assign o_data.sum_ch0       = r_sum[0];
    assign o_data.sum_ch1       = r_sum[1];
    assign o_data.sum_ch2       = r_sum[2];
    assign o_data.last_in_frame = r_d_last;

endmodule

/* src/conv3x3_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3x3_checker
// Port-level checks of the 3x3 correlation filter, bound to the top level.
// ----------------------------------------------------------------------------
module conv3x3_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_in_ready,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input conv3x3_pkg::t_sum_out                o_out_data,
    input logic                                 i_cfg_valid,
    input logic                                 o_cfg_ready
);

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or dropped while stalled");

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered straight after reset");

    // With the output free to drain, no pixel transfer is refused.
    a_full_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input stalled while output side was free");

    // The configuration port never back-pressures.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration transfer refused");

endmodule

bind conv3x3_image_filter conv3x3_checker u_checker (.*);
